// ===== sv/infix_to_postfix_converter_core_macros.svh =====
// Assertion macros for the infix to postfix converter core module.
// Depends on nothing; the asserting module must have clk and rst_n in scope.
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH
`ifndef SYNTH
`define IPC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ipc assertion failed");
`define IPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipc assertion failed");
`else
`define IPC_ASSERT_ALWAYS(label, prop)
`define IPC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/ipc_pkg.sv =====
// Types, character constants and operator tables for the infix to postfix converter.
// Depends on nothing.
package ipc_pkg;

    typedef logic [2:0] code_t;
    typedef logic [1:0] err_t;

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam code_t CODE_OPEN  = 3'd0;
    localparam code_t CODE_PLUS  = 3'd1;
    localparam code_t CODE_MINUS = 3'd2;
    localparam code_t CODE_STAR  = 3'd3;
    localparam code_t CODE_SLASH = 3'd4;
    localparam code_t CODE_CARET = 3'd5;

    localparam err_t ERR_NONE     = 2'd0;
    localparam err_t ERR_CLOSE    = 2'd1;
    localparam err_t ERR_OVERFLOW = 2'd2;
    localparam err_t ERR_OPEN     = 2'd3;

    typedef struct packed {
        logic [7:0] symbol;
        logic       symbol_valid;
        err_t       error_code;
    } result_t;

    typedef struct packed {
        logic    emit;
        logic    close;
        logic    close_last;
        result_t res;
    } rb_req_t;

    function automatic logic is_op(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
               (c == CH_SLASH) || (c == CH_CARET);
    endfunction

    function automatic code_t op_code(input logic [7:0] c);
        code_t r;
        case (c)
            CH_PLUS:  r = CODE_PLUS;
            CH_MINUS: r = CODE_MINUS;
            CH_STAR:  r = CODE_STAR;
            CH_SLASH: r = CODE_SLASH;
            CH_CARET: r = CODE_CARET;
            default:  r = CODE_OPEN;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] code_char(input code_t c);
        logic [7:0] r;
        case (c)
            CODE_PLUS:  r = CH_PLUS;
            CODE_MINUS: r = CH_MINUS;
            CODE_STAR:  r = CH_STAR;
            CODE_SLASH: r = CH_SLASH;
            CODE_CARET: r = CH_CARET;
            default:    r = CH_OPEN;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] code_prec(input code_t c);
        logic [2:0] r;
        case (c)
            CODE_PLUS, CODE_MINUS: r = 3'd2;
            CODE_STAR, CODE_SLASH: r = 3'd3;
            CODE_CARET:            r = 3'd4;
            default:               r = 3'd1;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/infix_to_postfix_converter_core.sv =====
// Infix to postfix converter top level: control sequencer around the operator
// stack memory and the result buffer. Depends on ipc_pkg, ipc_stack_mem, ipc_result_buf.
//
//   channel   | handshake           | payload
//   input     | in_valid, in_ready  | symbol, last
//   output    | out_valid, out_ready| out_symbol, symbol_valid, run_last, error_code
//
// A new symbol is accepted only once the previous one is done (in_ready is high only in idle).
// An operator or ')' pops the stack one entry at a time; each pop is a read of the
// stack memory, whose data is registered, then a compare and emit (read, then compare and emit).
// A last transaction then flushes every entry left on the stack, one read and emit each.
// Reset empties the stack at once; the stack memory itself needs no clearing.
// A stalled output holds the sequencer only when a result has to move forward.
`include "infix_to_postfix_converter_core_macros.svh"
module infix_to_postfix_converter_core #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] symbol,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_symbol,
    output logic       symbol_valid,
    output logic       run_last,
    output logic [1:0] error_code
);

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLASS,
        S_PUSH,
        S_POP_RD,
        S_POP_EV,
        S_LAST,
        S_FL_RD,
        S_FL_EV,
        S_END
    } state_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [7:0]       sym_reg, sym_next;
    logic             last_reg, last_next;
    ipc_pkg::code_t   code_reg, code_next;

    logic [CW-1:0]    count_m1;
    logic             stack_empty;
    logic             stack_full;
    logic             wr_en;
    logic             rd_en;
    ipc_pkg::code_t   rd_data;
    ipc_pkg::rb_req_t req;
    logic             ack;

    ipc_stack_mem #(
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (code_reg),
        .rd_en   (rd_en),
        .rd_addr (count_m1[AW-1:0]),
        .rd_data (rd_data)
    );

    ipc_result_buf u_rbuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .ack          (ack),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_symbol   (out_symbol),
        .symbol_valid (symbol_valid),
        .run_last     (run_last),
        .error_code   (error_code)
    );

    assign count_m1    = count_reg - CW'(1);
    assign stack_empty = (count_reg == '0);
    assign stack_full  = (count_reg == CW'(STACK_DEPTH));
    assign in_ready    = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        sym_next   = sym_reg;
        last_next  = last_reg;
        code_next  = code_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        req        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sym_next   = symbol;
                    last_next  = last;
                    code_next  = ipc_pkg::op_code(symbol);
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                if (sym_reg == ipc_pkg::CH_OPEN)
                begin
                    state_next = S_PUSH;
                end
                else if (sym_reg == ipc_pkg::CH_CLOSE || ipc_pkg::is_op(sym_reg))
                begin
                    state_next = S_POP_RD;
                end
                else
                begin
                    req.emit       = 1'b1;
                    req.res.symbol = sym_reg;
                    req.res.symbol_valid = 1'b1;
                    req.res.error_code   = ipc_pkg::ERR_NONE;
                    if (ack)
                    begin
                        state_next = S_LAST;
                    end
                end
            end
            S_PUSH:
            begin
                if (!stack_full)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = S_LAST;
                end
                else
                begin
                    req.emit       = 1'b1;
                    req.res.symbol = sym_reg;
                    req.res.symbol_valid = 1'b0;
                    req.res.error_code   = ipc_pkg::ERR_OVERFLOW;
                    if (ack)
                    begin
                        state_next = S_LAST;
                    end
                end
            end
            S_POP_RD:
            begin
                if (!stack_empty)
                begin
                    rd_en      = 1'b1;
                    state_next = S_POP_EV;
                end
                else if (sym_reg == ipc_pkg::CH_CLOSE)
                begin
                    req.emit       = 1'b1;
                    req.res.symbol = sym_reg;
                    req.res.symbol_valid = 1'b0;
                    req.res.error_code   = ipc_pkg::ERR_CLOSE;
                    if (ack)
                    begin
                        state_next = S_LAST;
                    end
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_POP_EV:
            begin
                if (sym_reg == ipc_pkg::CH_CLOSE && rd_data == ipc_pkg::CODE_OPEN)
                begin
                    count_next = count_m1;
                    state_next = S_LAST;
                end
                else if (sym_reg == ipc_pkg::CH_CLOSE ||
                         ipc_pkg::code_prec(rd_data) >= ipc_pkg::code_prec(code_reg))
                begin
                    req.emit       = 1'b1;
                    req.res.symbol = ipc_pkg::code_char(rd_data);
                    req.res.symbol_valid = 1'b1;
                    req.res.error_code   = ipc_pkg::ERR_NONE;
                    if (ack)
                    begin
                        count_next = count_m1;
                        state_next = S_POP_RD;
                    end
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_LAST:
            begin
                state_next = last_reg ? S_FL_RD : S_END;
            end
            S_FL_RD:
            begin
                if (stack_empty)
                begin
                    state_next = S_END;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_FL_EV;
                end
            end
            S_FL_EV:
            begin
                req.emit = 1'b1;
                if (rd_data == ipc_pkg::CODE_OPEN)
                begin
                    req.res.symbol       = ipc_pkg::CH_OPEN;
                    req.res.symbol_valid = 1'b0;
                    req.res.error_code   = ipc_pkg::ERR_OPEN;
                end
                else
                begin
                    req.res.symbol       = ipc_pkg::code_char(rd_data);
                    req.res.symbol_valid = 1'b1;
                    req.res.error_code   = ipc_pkg::ERR_NONE;
                end
                if (ack)
                begin
                    count_next = count_m1;
                    state_next = S_FL_RD;
                end
            end
            S_END:
            begin
                req.close      = 1'b1;
                req.close_last = last_reg;
                if (ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            sym_reg   <= '0;
            last_reg  <= 1'b0;
            code_reg  <= ipc_pkg::CODE_OPEN;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sym_reg   <= sym_next;
            last_reg  <= last_next;
            code_reg  <= code_next;
        end
    end

    // The stack never holds more entries than the memory has.
    `IPC_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(STACK_DEPTH))
    // A read is only issued for an entry that is on the stack.
    `IPC_ASSERT_ALWAYS(a_read_in_range, !rd_en || !stack_empty)
    // A write never lands on a full stack.
    `IPC_ASSERT_ALWAYS(a_write_in_range, !wr_en || !stack_full)
    // After a last transaction is finished, the stack is empty.
    `IPC_ASSERT_NEXT(a_flush_empties, state_reg == S_END && last_reg && ack, count_reg == '0)

endmodule

// ===== sv/ipc_stack_mem.sv =====
// Operator stack storage: one write port, one read port with registered data.
// Depends on ipc_pkg.
module ipc_stack_mem #(
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic           clk,
    input  logic           wr_en,
    input  logic [AW-1:0]  wr_addr,
    input  ipc_pkg::code_t wr_data,
    input  logic           rd_en,
    input  logic [AW-1:0]  rd_addr,
    output ipc_pkg::code_t rd_data
);

    ipc_pkg::code_t mem [DEPTH];
    ipc_pkg::code_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/ipc_result_buf.sv =====
// Result path: a one-entry hold stage that lets the final result of a transaction
// be marked, followed by the output register. Depends on ipc_pkg.
module ipc_result_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  ipc_pkg::rb_req_t req,
    output logic             ack,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_symbol,
    output logic             symbol_valid,
    output logic             run_last,
    output logic [1:0]       error_code
);

    logic              out_free;
    logic              out_valid_reg, out_valid_next;
    logic              pend_valid_reg, pend_valid_next;
    ipc_pkg::result_t  pend_reg, pend_next;
    ipc_pkg::result_t  out_reg, out_next;
    logic              last_reg, last_next;

    always_comb
    begin
        out_free        = !out_valid_reg || out_ready;
        out_valid_next  = out_valid_reg && !out_ready;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        last_next       = last_reg;
        ack             = 1'b0;
        if (req.emit)
        begin
            ack = !pend_valid_reg || out_free;
            if (ack)
            begin
                pend_next       = req.res;
                pend_valid_next = 1'b1;
                if (pend_valid_reg)
                begin
                    out_next       = pend_reg;
                    last_next      = 1'b0;
                    out_valid_next = 1'b1;
                end
            end
        end
        else if (req.close)
        begin
            ack = out_free || (!pend_valid_reg && !req.close_last);
            if (ack)
            begin
                pend_valid_next = 1'b0;
                if (req.close_last)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_next = pend_reg;
                    end
                    else
                    begin
                        out_next = '{symbol: ipc_pkg::CH_NUL, symbol_valid: 1'b0,
                                     error_code: ipc_pkg::ERR_NONE};
                    end
                end
                else if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b0;
                    out_next       = pend_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
        last_reg <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_symbol   = out_reg.symbol;
    assign symbol_valid = out_reg.symbol_valid;
    assign error_code   = out_reg.error_code;
    assign run_last     = last_reg;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for infix_to_postfix_converter_core: infix characters go in one per
// transaction and each postfix result is checked against an operator-stack predictor.
// Depends on ipc_pkg and the converter RTL.
module testbench;

    localparam int STACK_DEPTH = 16;
    localparam int TARGET_ITEMS = 460;
    localparam int DRAIN_CYCLES = 4 + 4 * (STACK_DEPTH + 1) + 20;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [7:0]    sym;
        logic          sym_ok;
        logic          end_mark;
        ipc_pkg::err_t err;
    } postfix_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] symbol;
    logic       last;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_symbol;
    logic       symbol_valid;
    logic       run_last;
    logic [1:0] error_code;

    postfix_t       expected_postfix_q[$];
    ipc_pkg::code_t op_stack_model[STACK_DEPTH];
    int             op_depth = 0;
    int             items_sent = 0;
    int             mismatches = 0;
    int             stall_left = 0;
    int unsigned    cycle_count = 0;
    bit             quiet_in = 1'b0;
    bit             quiet_out = 1'b0;

    infix_to_postfix_converter_core #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .symbol(symbol),
        .last(last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_symbol(out_symbol),
        .symbol_valid(symbol_valid),
        .run_last(run_last),
        .error_code(error_code)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_postfix_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, field, got, want);
    endtask

    function automatic int rank_of(input ipc_pkg::code_t c);
        case (c)
            ipc_pkg::CODE_PLUS, ipc_pkg::CODE_MINUS: return 2;
            ipc_pkg::CODE_STAR, ipc_pkg::CODE_SLASH: return 3;
            ipc_pkg::CODE_CARET:                     return 4;
            default:                                 return 1;
        endcase
    endfunction

    function automatic logic [7:0] char_of(input ipc_pkg::code_t c);
        case (c)
            ipc_pkg::CODE_PLUS:  return ipc_pkg::CH_PLUS;
            ipc_pkg::CODE_MINUS: return ipc_pkg::CH_MINUS;
            ipc_pkg::CODE_STAR:  return ipc_pkg::CH_STAR;
            ipc_pkg::CODE_SLASH: return ipc_pkg::CH_SLASH;
            ipc_pkg::CODE_CARET: return ipc_pkg::CH_CARET;
            default:             return ipc_pkg::CH_OPEN;
        endcase
    endfunction

    function automatic void expect_postfix(input logic [7:0] s, input logic ok,
                                           input ipc_pkg::err_t e);
        postfix_t r;
        r.sym = s;
        r.sym_ok = ok;
        r.end_mark = 1'b0;
        r.err = e;
        expected_postfix_q.push_back(r);
    endfunction

    function automatic void convert_symbol(input logic [7:0] c, input logic is_last);
        int             first;
        ipc_pkg::code_t top;
        ipc_pkg::code_t incoming;
        logic           is_op;
        logic           matched;
        postfix_t       tail;
        first = expected_postfix_q.size();
        is_op = 1'b1;
        case (c)
            ipc_pkg::CH_PLUS:  incoming = ipc_pkg::CODE_PLUS;
            ipc_pkg::CH_MINUS: incoming = ipc_pkg::CODE_MINUS;
            ipc_pkg::CH_STAR:  incoming = ipc_pkg::CODE_STAR;
            ipc_pkg::CH_SLASH: incoming = ipc_pkg::CODE_SLASH;
            ipc_pkg::CH_CARET: incoming = ipc_pkg::CODE_CARET;
            default:
            begin
                incoming = ipc_pkg::CODE_OPEN;
                is_op = 1'b0;
            end
        endcase
        if (c == ipc_pkg::CH_OPEN)
        begin
            if (op_depth < STACK_DEPTH)
            begin
                op_stack_model[op_depth] = ipc_pkg::CODE_OPEN;
                op_depth++;
            end
            else
                expect_postfix(c, 1'b0, ipc_pkg::ERR_OVERFLOW);
        end
        else if (c == ipc_pkg::CH_CLOSE)
        begin
            matched = 1'b0;
            while (!matched && op_depth > 0)
            begin
                op_depth--;
                top = op_stack_model[op_depth];
                if (top == ipc_pkg::CODE_OPEN)
                    matched = 1'b1;
                else
                    expect_postfix(char_of(top), 1'b1, ipc_pkg::ERR_NONE);
            end
            if (!matched)
                expect_postfix(c, 1'b0, ipc_pkg::ERR_CLOSE);
        end
        else if (is_op)
        begin
            while (op_depth > 0 && rank_of(op_stack_model[op_depth - 1]) >= rank_of(incoming))
            begin
                op_depth--;
                expect_postfix(char_of(op_stack_model[op_depth]), 1'b1, ipc_pkg::ERR_NONE);
            end
            if (op_depth < STACK_DEPTH)
            begin
                op_stack_model[op_depth] = incoming;
                op_depth++;
            end
            else
                expect_postfix(c, 1'b0, ipc_pkg::ERR_OVERFLOW);
        end
        else
            expect_postfix(c, 1'b1, ipc_pkg::ERR_NONE);

        if (is_last)
        begin
            while (op_depth > 0)
            begin
                op_depth--;
                top = op_stack_model[op_depth];
                if (top == ipc_pkg::CODE_OPEN)
                    expect_postfix(ipc_pkg::CH_OPEN, 1'b0, ipc_pkg::ERR_OPEN);
                else
                    expect_postfix(char_of(top), 1'b1, ipc_pkg::ERR_NONE);
            end
            if (expected_postfix_q.size() == first)
                expect_postfix(ipc_pkg::CH_NUL, 1'b0, ipc_pkg::ERR_NONE);
            tail = expected_postfix_q.pop_back();
            tail.end_mark = 1'b1;
            expected_postfix_q.push_back(tail);
        end
    endfunction

    always @(posedge clk)
    begin
        postfix_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready)
        begin
            if (expected_postfix_q.size() == 0)
                report_mismatch("result with none expected, out_symbol", out_symbol,
                                ipc_pkg::CH_NUL);
            else
            begin
                want = expected_postfix_q.pop_front();
                if (out_symbol !== want.sym)
                    report_mismatch("out_symbol", out_symbol, want.sym);
                if (symbol_valid !== want.sym_ok)
                    report_mismatch("symbol_valid", {7'd0, symbol_valid}, {7'd0, want.sym_ok});
                if (run_last !== want.end_mark)
                    report_mismatch("run_last", {7'd0, run_last}, {7'd0, want.end_mark});
                if (error_code !== want.err)
                    report_mismatch("error_code", {6'd0, error_code}, {6'd0, want.err});
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!quiet_out && $urandom_range(0, 99) < 25)
        begin
            stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                     : $urandom_range(5, 23);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_in || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic send_symbol(input logic [7:0] c, input logic is_last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        symbol <= c;
        last <= is_last;
        if (!in_valid)
            in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        convert_symbol(c, is_last);
        items_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_symbol(text[i], i == text.len() - 1);
    endtask

    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 4))
            0:       return ipc_pkg::CH_PLUS;
            1:       return ipc_pkg::CH_MINUS;
            2:       return ipc_pkg::CH_STAR;
            3:       return ipc_pkg::CH_SLASH;
            default: return ipc_pkg::CH_CARET;
        endcase
    endfunction

    function automatic logic [7:0] random_special();
        case ($urandom_range(0, 6))
            0:       return ipc_pkg::CH_OPEN;
            1:       return ipc_pkg::CH_CLOSE;
            default: return random_operator();
        endcase
    endfunction

    function automatic logic [7:0] random_operand();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == ipc_pkg::CH_OPEN || c == ipc_pkg::CH_CLOSE || c == ipc_pkg::CH_PLUS ||
               c == ipc_pkg::CH_MINUS || c == ipc_pkg::CH_STAR || c == ipc_pkg::CH_SLASH ||
               c == ipc_pkg::CH_CARET);
        return c;
    endfunction

    task automatic send_random_expression(input int max_terms, input int max_nest);
        logic [7:0] expr_q[$];
        int         goal;
        int         terms;
        int         open_now;
        int         pos;
        goal = $urandom_range(1, max_terms);
        terms = 0;
        open_now = 0;
        while (terms < goal)
        begin
            while (open_now < max_nest && $urandom_range(0, 3) == 0)
            begin
                expr_q.push_back(ipc_pkg::CH_OPEN);
                open_now++;
            end
            expr_q.push_back(random_operand());
            terms++;
            while (open_now > 0 && $urandom_range(0, 2) == 0)
            begin
                expr_q.push_back(ipc_pkg::CH_CLOSE);
                open_now--;
            end
            if (terms < goal)
                expr_q.push_back(random_operator());
        end
        repeat (open_now) expr_q.push_back(ipc_pkg::CH_CLOSE);
        if ($urandom_range(0, 9) == 0)
        begin
            pos = $urandom_range(0, expr_q.size() - 1);
            if ($urandom_range(0, 1) == 0 && expr_q.size() > 1)
                expr_q.delete(pos);
            else
                expr_q.insert(pos, random_special());
        end
        for (int i = 0; i < expr_q.size(); i++)
            send_symbol(expr_q[i], i == expr_q.size() - 1);
    endtask

    task automatic test_single_symbols();
        send_symbol(ipc_pkg::CH_NUL, 1'b1);
        send_symbol(8'hFF, 1'b1);
        send_text("#");
    endtask

    task automatic test_precedence();
        send_text("a^b^c*d/e-f+g");
    endtask

    task automatic test_parentheses();
        send_text("()");
        send_text(")");
        send_text("a+)");
        send_text("(b");
    endtask

    task automatic test_deep_nesting();
        int opens;
        repeat (6)
        begin
            opens = $urandom_range(11, STACK_DEPTH + 2);
            repeat (opens) send_symbol(ipc_pkg::CH_OPEN, 1'b0);
            send_symbol(random_operand(), 1'b0);
            send_symbol(ipc_pkg::CH_PLUS, 1'b0);
            send_symbol(random_operand(), 1'b0);
            send_symbol(ipc_pkg::CH_STAR, 1'b0);
            send_symbol(random_operand(), 1'b0);
            send_symbol(ipc_pkg::CH_CARET, 1'b0);
            repeat ($urandom_range(0, 3)) send_symbol(random_special(), 1'b0);
            if ($urandom_range(0, 1) == 0)
                send_symbol(ipc_pkg::CH_OPEN, 1'b1);
            else
                send_symbol(random_operand(), 1'b1);
        end
    endtask

    task automatic test_random_expressions(input int stop_at);
        quiet_in = 1'b1;
        quiet_out = 1'b1;
        while (items_sent < stop_at)
        begin
            if (items_sent > 150)
            begin
                quiet_in = 1'b0;
                quiet_out = 1'b0;
            end
            if ($urandom_range(0, 15) == 0)
                send_random_expression(12, 8);
            else
                send_random_expression(6, 3);
        end
    endtask

    task automatic test_noise(input int count);
        quiet_out = 1'b1;
        repeat (count)
        begin
            if (items_sent % 40 == 0)
                quiet_out = ~quiet_out;
            if ($urandom_range(0, 1) == 0)
                send_symbol(random_special(), $urandom_range(0, 5) == 0);
            else
                send_symbol(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
        end
        quiet_out = 1'b0;
        send_symbol(random_operand(), 1'b1);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        symbol <= ipc_pkg::CH_NUL;
        last <= 1'b0;
        out_ready <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_single_symbols();
        test_precedence();
        test_parentheses();
        test_deep_nesting();
        test_random_expressions(TARGET_ITEMS - 80);
        test_noise(80);

        in_valid <= 1'b0;
        while (expected_postfix_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
